/* rtl/etos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etos_pkg: shared types and constants of the escape-time orbit step
// Holds the configuration register indexes, bailout mode codes, default
// parameter values and the stage control struct.
// ----------------------------------------------------------------------------
package etos_pkg;

	// default geometry of the fixed-point coordinates
	localparam int unsigned FRAC_BITS_DEF   = 28;
	localparam int unsigned COORD_WIDTH_DEF = 32;

	// squared measures and the escape limit are 36-bit unsigned
	localparam int unsigned MAG_WIDTH = 36;
	localparam logic [MAG_WIDTH-1:0] MAG_MAX = {MAG_WIDTH{1'b1}};
	localparam logic [MAG_WIDTH-1:0] LIMIT_RESET = 36'h0_4000_0000;

	// configuration register indexes
	localparam int unsigned CFG_IDX_WIDTH = 1;
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_BAILOUT_MODE = 1'b0,
		REG_ESCAPE_LIMIT = 1'b1
	} cfg_reg_t;

	// bailout test codes; the unused code acts as modulus
	localparam int unsigned MODE_WIDTH = 3;
	typedef enum logic [MODE_WIDTH-1:0] {
		BAIL_MODULUS   = 3'd0,
		BAIL_REAL      = 3'd1,
		BAIL_IMAG      = 3'd2,
		BAIL_OR        = 3'd3,
		BAIL_AND       = 3'd4,
		BAIL_MANHATTAN = 3'd5,
		BAIL_MANH_RAW  = 3'd6
	} bail_mode_t;

	// load enables for the two register stages inside one datapath unit
	typedef struct packed {
		logic first;
		logic second;
	} etos_adv_t;

endpackage

/* rtl/etos_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etos_cfg_regs: configuration registers
// Bailout mode and escape limit, written through a plain write port.
// ----------------------------------------------------------------------------
module etos_cfg_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [etos_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [etos_pkg::MAG_WIDTH-1:0]        cfg_wdata,
	output logic [etos_pkg::MODE_WIDTH-1:0]       mode_q,
	output logic [etos_pkg::MAG_WIDTH-1:0]        limit_q
);
	import etos_pkg::*;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= BAIL_MODULUS;
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BAILOUT_MODE: mode_q  <= cfg_wdata[MODE_WIDTH-1:0];
				REG_ESCAPE_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/etos_zstep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etos_zstep: z' = z^2 + c datapath, two stages
// Stage 1 forms the exact products x*x, y*y and x*y. Stage 2 scales them
// down with floor rounding, adds c and saturates each part.
// ----------------------------------------------------------------------------
module etos_zstep #(
	parameter int unsigned FRAC_BITS   = etos_pkg::FRAC_BITS_DEF,
	parameter int unsigned COORD_WIDTH = etos_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  etos_pkg::etos_adv_t           adv,
	input  logic signed [COORD_WIDTH-1:0] old_re,
	input  logic signed [COORD_WIDTH-1:0] old_im,
	input  logic signed [COORD_WIDTH-1:0] const_re,
	input  logic signed [COORD_WIDTH-1:0] const_im,
	output logic signed [COORD_WIDTH-1:0] nx_s2,
	output logic signed [COORD_WIDTH-1:0] ny_s2
);
	import etos_pkg::*;

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned PW = 2 * W + 1;

	logic signed [2*W-1:0] xx_s1, yy_s1, xy_s1;
	logic signed [W-1:0]   cre_s1, cim_s1;
	logic signed [PW-1:0]  diff, re_pre, im_pre;

	// clamp a wide signed value to the coordinate range
	function automatic logic signed [W-1:0] sat_coord(input logic signed [PW-1:0] v);
		logic [PW-W:0] upper;
		logic signed [W-1:0] r;
		upper = v[PW-1:W-1];
		if ((&upper) || !(|upper))
			r = $signed(v[W-1:0]);
		else if (v[PW-1])
			r = $signed({1'b1, {(W-1){1'b0}}});
		else
			r = $signed({1'b0, {(W-1){1'b1}}});
		return r;
	endfunction

	// stage 1: exact products
	always_ff @(posedge clk) begin
		if (adv.first) begin
			xx_s1  <= old_re * old_re;
			yy_s1  <= old_im * old_im;
			xy_s1  <= old_re * old_im;
			cre_s1 <= const_re;
			cim_s1 <= const_im;
		end
	end

	// stage 2: floor scaling, add c, saturate
	always_comb begin
		diff   = PW'(xx_s1) - PW'(yy_s1);
		re_pre = (diff >>> FRAC_BITS) + PW'(cre_s1);
		im_pre = (PW'(xy_s1) >>> (FRAC_BITS - 1)) + PW'(cim_s1);
	end

	always_ff @(posedge clk) begin
		if (adv.second) begin
			nx_s2 <= sat_coord(re_pre);
			ny_s2 <= sat_coord(im_pre);
		end
	end

endmodule

/* rtl/etos_bailout.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etos_bailout: squared measures and bailout test, two stages
// Stage 3 squares |x'|, |y'| and the Manhattan operand. Stage 4 scales and
// saturates them, sums the modulus and compares against the limit.
// ----------------------------------------------------------------------------
module etos_bailout #(
	parameter int unsigned FRAC_BITS   = etos_pkg::FRAC_BITS_DEF,
	parameter int unsigned COORD_WIDTH = etos_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  etos_pkg::etos_adv_t                 adv,
	input  logic [etos_pkg::MODE_WIDTH-1:0]     mode,
	input  logic [etos_pkg::MAG_WIDTH-1:0]      limit,
	input  logic signed [COORD_WIDTH-1:0]       nx,
	input  logic signed [COORD_WIDTH-1:0]       ny,
	output logic signed [COORD_WIDTH-1:0]       new_re_s4,
	output logic signed [COORD_WIDTH-1:0]       new_im_s4,
	output logic [etos_pkg::MAG_WIDTH-1:0]      mag_s4,
	output logic                                esc_s4
);
	import etos_pkg::*;

	localparam int unsigned W   = COORD_WIDTH;
	localparam int unsigned MW  = W + 1;
	localparam int unsigned PRW = 2 * MW;
	localparam int unsigned M   = MAG_WIDTH;
	localparam int unsigned QW  = (PRW > M + 1) ? PRW : M + 1;

	logic [W-1:0]         ax, ay;
	logic signed [MW-1:0] raw_sum;
	logic [MW-1:0]        man;
	logic [PRW-1:0]       sqx_s3, sqy_s3, sqm_s3;
	logic signed [W-1:0]  nx_s3, ny_s3;
	logic [M-1:0]         sx, sy, sm, mag;
	logic [M:0]           mag_sum;
	logic                 esc;

	// floor(p / 2^F), saturated to the measure width
	function automatic logic [M-1:0] sq_sat(input logic [PRW-1:0] p);
		logic [QW-1:0] q;
		logic [M-1:0]  r;
		q = QW'(p >> FRAC_BITS);
		if (|q[QW-1:M])
			r = MAG_MAX;
		else
			r = q[M-1:0];
		return r;
	endfunction

	// stage 3: magnitudes and the Manhattan operand
	always_comb begin
		ax      = nx[W-1] ? W'(-nx) : W'(nx);
		ay      = ny[W-1] ? W'(-ny) : W'(ny);
		raw_sum = MW'(nx) + MW'(ny);
		if (mode == BAIL_MANH_RAW)
			man = raw_sum[MW-1] ? MW'(-raw_sum) : MW'(raw_sum);
		else
			man = MW'(ax) + MW'(ay);
	end

	always_ff @(posedge clk) begin
		if (adv.first) begin
			sqx_s3 <= MW'(ax) * MW'(ax);
			sqy_s3 <= MW'(ay) * MW'(ay);
			sqm_s3 <= man * man;
			nx_s3  <= nx;
			ny_s3  <= ny;
		end
	end

	// stage 4: scale, sum, compare
	always_comb begin
		sx      = sq_sat(sqx_s3);
		sy      = sq_sat(sqy_s3);
		sm      = sq_sat(sqm_s3);
		mag_sum = (M+1)'(sx) + (M+1)'(sy);
		mag     = mag_sum[M] ? MAG_MAX : mag_sum[M-1:0];
		case (mode)
			BAIL_REAL:      esc = (sx >= limit);
			BAIL_IMAG:      esc = (sy >= limit);
			BAIL_OR:        esc = (sx >= limit) || (sy >= limit);
			BAIL_AND:       esc = (sx >= limit) && (sy >= limit);
			BAIL_MANHATTAN: esc = (sm >= limit);
			BAIL_MANH_RAW:  esc = (sm >= limit);
			default:        esc = (mag >= limit);
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.second) begin
			new_re_s4 <= nx_s3;
			new_im_s4 <= ny_s3;
			mag_s4    <= mag;
			esc_s4    <= esc;
		end
	end

endmodule

/* rtl/escape_time_orbit_step.sv */
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; four register
// stages (products, z' sum and saturation, squared measures, scale and compare)
// each hold one word.
// A stall on the output backs up stage by stage; bubbles are filled first.
// Reset clears all stage valid bits, sets bailout mode to modulus and the
// escape limit to 2^30.
// ----------------------------------------------------------------------------
// escape_time_orbit_step: one quadratic orbit step with bailout test
// Forms z' = z^2 + c in saturating fixed point, its squared modulus and a
// selectable escape flag, in a four-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
module escape_time_orbit_step #(
	parameter int unsigned FRAC_BITS   = etos_pkg::FRAC_BITS_DEF,
	parameter int unsigned COORD_WIDTH = etos_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_wr_en,
	input  logic [etos_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [etos_pkg::MAG_WIDTH-1:0]     cfg_wdata,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_WIDTH-1:0]      old_re,
	input  logic signed [COORD_WIDTH-1:0]      old_im,
	input  logic signed [COORD_WIDTH-1:0]      const_re,
	input  logic signed [COORD_WIDTH-1:0]      const_im,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_WIDTH-1:0]      new_re,
	output logic signed [COORD_WIDTH-1:0]      new_im,
	output logic [etos_pkg::MAG_WIDTH-1:0]     magnitude,
	output logic                               escaped
);
	import etos_pkg::*;

	logic [MODE_WIDTH-1:0]        mode_q;
	logic [MAG_WIDTH-1:0]         limit_q;
	logic                         valid_s1, valid_s2, valid_s3, valid_s4;
	logic                         adv1, adv2, adv3, adv4;
	etos_adv_t                    adv_front, adv_back;
	logic signed [COORD_WIDTH-1:0] nx_s2, ny_s2;

	etos_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.mode_q    (mode_q),
		.limit_q   (limit_q)
	);

	// stage advance: a stage loads when it is empty or its word moves on
	always_comb begin
		adv4             = !valid_s4 || out_ready;
		adv3             = !valid_s3 || adv4;
		adv2             = !valid_s2 || adv3;
		adv1             = !valid_s1 || adv2;
		adv_front.first  = adv1;
		adv_front.second = adv2;
		adv_back.first   = adv3;
		adv_back.second  = adv4;
	end

	assign in_ready  = adv1;
	assign out_valid = valid_s4;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	etos_zstep #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_zstep (
		.clk      (clk),
		.adv      (adv_front),
		.old_re   (old_re),
		.old_im   (old_im),
		.const_re (const_re),
		.const_im (const_im),
		.nx_s2    (nx_s2),
		.ny_s2    (ny_s2)
	);

	etos_bailout #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_bail (
		.clk       (clk),
		.adv       (adv_back),
		.mode      (mode_q),
		.limit     (limit_q),
		.nx        (nx_s2),
		.ny        (ny_s2),
		.new_re_s4 (new_re),
		.new_im_s4 (new_im),
		.mag_s4    (magnitude),
		.esc_s4    (escaped)
	);

endmodule

/* rtl/etos_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etos_checker: port-level checks of the orbit step pipeline
// Watches the top-level ports for output hold, reset state, backpressure
// propagation and the fixed latency through an unstalled pipeline.
// ----------------------------------------------------------------------------
module etos_checker #(
	parameter int unsigned COORD_WIDTH = etos_pkg::COORD_WIDTH_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [COORD_WIDTH-1:0]      new_re,
	input logic signed [COORD_WIDTH-1:0]      new_im,
	input logic [etos_pkg::MAG_WIDTH-1:0]     magnitude,
	input logic                               escaped
);
	import etos_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_re) && $stable(new_im)
			&& $stable(magnitude) && $stable(escaped))
		else $error("stalled result word changed");

	// reset leaves the output channel empty
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

	// a draining output lets every stage move, so the input is open
	a_ready_chain: assert property (@(posedge clk)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// an unstalled word comes out after passing every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after four unstalled cycles");

endmodule

bind escape_time_orbit_step etos_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_etos_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.new_re    (new_re),
	.new_im    (new_im),
	.magnitude (magnitude),
	.escaped   (escaped)
);
